// ----- rtl/core/hrb_pkg.sv -----
// shared types and constants for the holding register bank
`default_nettype none

package hrb_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_SCAN   = 3'd2,
        OP_LWRITE = 3'd3,
        OP_LREAD  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_HEADER = 3'd0,
        K_DATA   = 3'd1,
        K_ECHO   = 3'd2,
        K_ERROR  = 3'd3,
        K_CHANGE = 3'd4,
        K_LOCAL  = 3'd5
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [15:0] start_address;
        logic [15:0] word_count;
        logic [15:0] data_word;
        logic [15:0] local_index;
        logic        last_word;
        logic        range_ok;
        logic        local_ok;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  byte_count;
        logic [5:0]  register_number;
        logic [15:0] value_out;
        logic [15:0] echo_start;
        logic [15:0] echo_count;
        logic        last_result;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/core/hrb_front.sv -----
// front end: takes requests, drops unknown operations and runs the range checks
`default_nettype none

module hrb_front
    import hrb_pkg::*;
#(
    parameter int unsigned REGISTER_COUNT = 32
) (
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [2:0]  i_operation,
    input  wire logic [15:0] i_start_address,
    input  wire logic [15:0] i_word_count,
    input  wire logic [15:0] i_data_word,
    input  wire logic [15:0] i_local_index,
    input  wire logic        i_last_word,
    output t_cmd             o_cmd,
    output logic             o_push
);

    logic        known;
    logic [16:0] range_end;

    always_comb begin
        case (t_op'(i_operation))
            OP_READ, OP_WRITE, OP_SCAN, OP_LWRITE, OP_LREAD: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign range_end = {1'b0, i_start_address} + {1'b0, i_word_count};

    always_comb begin
        o_cmd.op            = t_op'(i_operation);
        o_cmd.start_address = i_start_address;
        o_cmd.word_count    = i_word_count;
        o_cmd.data_word     = i_data_word;
        o_cmd.local_index   = i_local_index;
        o_cmd.last_word     = i_last_word;
        o_cmd.range_ok      = (i_word_count != 16'd0) && (range_end <= 17'(REGISTER_COUNT));
        o_cmd.local_ok      = (i_local_index != 16'd0)
                              && (i_local_index <= 16'(REGISTER_COUNT));
    end

    assign o_push = i_push && !i_full && known;

endmodule

`default_nettype wire

// ----- rtl/core/hrb_queue.sv -----
// short command queue between front end and back end
`default_nettype none

module hrb_queue
    import hrb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_valid
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/hrb_back.sv -----
// back end: register bank, shadow copy, read and scan sequencing, result register
`default_nettype none

module hrb_back
    import hrb_pkg::*;
#(
    parameter int unsigned REGISTER_COUNT = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cmd      i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    output t_res      o_res,
    output logic      o_res_valid,
    input  wire logic i_res_pop
);

    localparam int unsigned AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int unsigned PW = $clog2(REGISTER_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [15:0]         r_reg    [REGISTER_COUNT];
    logic [15:0]         r_shadow [REGISTER_COUNT];
    logic [PW-1:0]       r_wpos;
    logic [PW-1:0]       n_wpos;
    logic [AW-1:0]       r_raddr;
    logic [AW-1:0]       n_raddr;
    logic [PW-1:0]       r_rem;
    logic [PW-1:0]       n_rem;
    logic [AW-1:0]       r_sidx;
    logic [AW-1:0]       n_sidx;
    t_res                r_out;
    logic                r_out_valid;

    logic [REGISTER_COUNT-1:0] diff;
    logic [REGISTER_COUNT-1:0] above;
    logic                      slot_free;
    logic                      out_load;
    t_res                      res;
    logic                      reg_we;
    logic [AW-1:0]             reg_waddr;
    logic                      sh_we;
    logic [AW-1:0]             laddr;

    assign slot_free = !r_out_valid || i_res_pop;
    assign laddr     = AW'(i_cmd.local_index - 16'd1);

    always_comb begin
        for (int j = 0; j < REGISTER_COUNT; j++) begin
            diff[j]  = (r_reg[j] != r_shadow[j]);
            above[j] = (j > int'(r_sidx));
        end
    end

    always_comb begin
        n_state   = r_state;
        n_wpos    = r_wpos;
        n_raddr   = r_raddr;
        n_rem     = r_rem;
        n_sidx    = r_sidx;
        o_cmd_pop = 1'b0;
        out_load  = 1'b0;
        res       = '0;
        reg_we    = 1'b0;
        reg_waddr = '0;
        sh_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_READ: begin
                            out_load = 1'b1;
                            if (!i_cmd.range_ok) begin
                                res.kind        = K_ERROR;
                                res.last_result = 1'b1;
                            end else begin
                                res.kind       = K_HEADER;
                                res.byte_count = {i_cmd.word_count[5:0], 1'b0};
                                n_raddr        = i_cmd.start_address[AW-1:0];
                                n_rem          = i_cmd.word_count[PW-1:0];
                                n_state        = S_READ;
                            end
                        end
                        OP_WRITE: begin
                            if (i_cmd.range_ok && (16'(r_wpos) < i_cmd.word_count)) begin
                                reg_we    = 1'b1;
                                reg_waddr = i_cmd.start_address[AW-1:0] + AW'(r_wpos);
                                n_wpos    = r_wpos + PW'(1);
                            end
                            if (i_cmd.last_word) begin
                                n_wpos          = '0;
                                out_load        = 1'b1;
                                res.last_result = 1'b1;
                                if (i_cmd.range_ok) begin
                                    res.kind       = K_ECHO;
                                    res.echo_start = i_cmd.start_address;
                                    res.echo_count = i_cmd.word_count;
                                end else begin
                                    res.kind = K_ERROR;
                                end
                            end
                        end
                        OP_SCAN: begin
                            n_sidx  = '0;
                            n_state = S_SCAN;
                        end
                        OP_LWRITE: begin
                            if (i_cmd.local_ok) begin
                                reg_we    = 1'b1;
                                reg_waddr = laddr;
                            end
                        end
                        OP_LREAD: begin
                            out_load        = 1'b1;
                            res.kind        = K_LOCAL;
                            res.value_out   = i_cmd.local_ok ? r_reg[laddr] : 16'd0;
                            res.last_result = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (slot_free) begin
                    out_load        = 1'b1;
                    res.kind        = K_DATA;
                    res.value_out   = r_reg[r_raddr];
                    res.last_result = (r_rem == PW'(1));
                    n_raddr         = r_raddr + AW'(1);
                    n_rem           = r_rem - PW'(1);
                    if (r_rem == PW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (!diff[r_sidx] || slot_free) begin
                    sh_we = 1'b1;
                    if (diff[r_sidx]) begin
                        out_load            = 1'b1;
                        res.kind            = K_CHANGE;
                        res.register_number = 6'(r_sidx) + 6'd1;
                        res.value_out       = r_reg[r_sidx];
                        res.last_result     = ((diff & above) == '0);
                    end
                    n_sidx = r_sidx + AW'(1);
                    if (r_sidx == AW'(REGISTER_COUNT - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wpos      <= '0;
            r_raddr     <= '0;
            r_rem       <= '0;
            r_sidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wpos  <= n_wpos;
            r_raddr <= n_raddr;
            r_rem   <= n_rem;
            r_sidx  <= n_sidx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < REGISTER_COUNT; j++) begin
                r_reg[j]    <= '0;
                r_shadow[j] <= '0;
            end
        end else begin
            if (reg_we) begin
                r_reg[reg_waddr] <= i_cmd.data_word;
            end
            if (sh_we) begin
                r_shadow[r_sidx] <= r_reg[r_sidx];
            end
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= PW'(REGISTER_COUNT))
        else $error("write position beyond bank");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rem != '0))
        else $error("read run with no words left");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE))
        else $error("request taken while a run is active");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> i_res_pop)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ----- rtl/core/modbus_holding_register_bank.sv -----
// holding register bank top level: front end, request queue, back end
//
//  channel   direction  handshake             payload
//  request   in         push / full           i_operation .. i_last_word
//  result    out        empty / pop           o_result_kind .. o_last_result
//
// a request enters the queue in the cycle it is accepted and is registered there before it reaches the back end
// read: the header or error first, then one data result per word
// scan: a start step, then each of the REGISTER_COUNT registers in turn; a change notice
// waits for the result slot
// write word, local write and local read: each is handled in the idle state of the back end
// reset is synchronous and clears the bank, the shadow copy and all control state
// a result waiting in the result register holds back only the back end; the queue keeps filling
`default_nettype none

module modbus_holding_register_bank
    import hrb_pkg::*;
#(
    parameter int unsigned REGISTER_COUNT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_operation,
    input  wire logic [15:0] i_start_address,
    input  wire logic [15:0] i_word_count,
    input  wire logic [15:0] i_data_word,
    input  wire logic [15:0] i_local_index,
    input  wire logic        i_last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_result_kind,
    output logic [6:0]       o_byte_count,
    output logic [5:0]       o_register_number,
    output logic [15:0]      o_value_out,
    output logic [15:0]      o_echo_start,
    output logic [15:0]      o_echo_count,
    output logic             o_last_result
);

    t_cmd front_cmd;
    logic front_push;
    t_cmd head_cmd;
    logic head_valid;
    logic head_pop;
    t_res res;
    logic res_valid;

    hrb_front #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_front (
        .i_push         (push),
        .i_full         (full),
        .i_operation    (i_operation),
        .i_start_address(i_start_address),
        .i_word_count   (i_word_count),
        .i_data_word    (i_data_word),
        .i_local_index  (i_local_index),
        .i_last_word    (i_last_word),
        .o_cmd          (front_cmd),
        .o_push         (front_push)
    );

    hrb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_cmd  (front_cmd),
        .o_full (full),
        .i_pop  (head_pop),
        .o_cmd  (head_cmd),
        .o_valid(head_valid)
    );

    hrb_back #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_cmd_valid(head_valid),
        .o_cmd_pop  (head_pop),
        .o_res      (res),
        .o_res_valid(res_valid),
        .i_res_pop  (pop)
    );

    assign empty             = !res_valid;
    assign o_result_kind     = res.kind;
    assign o_byte_count      = res.byte_count;
    assign o_register_number = res.register_number;
    assign o_value_out       = res.value_out;
    assign o_echo_start      = res.echo_start;
    assign o_echo_count      = res.echo_count;
    assign o_last_result     = res.last_result;

endmodule

`default_nettype wire

// ----- verif/tb_modbus_holding_register_bank.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the holding register bank: directed table, random traffic, scoreboard

module tb_modbus_holding_register_bank
    import hrb_pkg::*;
();

    localparam int BANK_DEPTH     = 32;
    localparam int RANDOM_ITEMS   = 370;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] start;
        logic [15:0] count;
        logic [15:0] data;
        logic [15:0] lidx;
        logic        last;
    } t_req;

    typedef struct {
        t_req req;
        bit   has_reply;
        t_res reply;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [2:0]  i_operation = '0;
    logic [15:0] i_start_address = '0;
    logic [15:0] i_word_count = '0;
    logic [15:0] i_data_word = '0;
    logic [15:0] i_local_index = '0;
    logic        i_last_word = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  o_result_kind;
    logic [6:0]  o_byte_count;
    logic [5:0]  o_register_number;
    logic [15:0] o_value_out;
    logic [15:0] o_echo_start;
    logic [15:0] o_echo_count;
    logic        o_last_result;

    logic [15:0] bank_regs [BANK_DEPTH];
    logic [15:0] shadow_regs [BANK_DEPTH];
    logic [15:0] run_taken;

    t_res        replies_due [$];
    t_script_row script [$];
    int          mismatches = 0;
    int          random_sent = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    logic [7:0]  stall_phase = '0;

    modbus_holding_register_bank #(
        .REGISTER_COUNT(BANK_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_operation      (i_operation),
        .i_start_address  (i_start_address),
        .i_word_count     (i_word_count),
        .i_data_word      (i_data_word),
        .i_local_index    (i_local_index),
        .i_last_word      (i_last_word),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (o_result_kind),
        .o_byte_count     (o_byte_count),
        .o_register_number(o_register_number),
        .o_value_out      (o_value_out),
        .o_echo_start     (o_echo_start),
        .o_echo_count     (o_echo_count),
        .o_last_result    (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_res closing_reply(t_kind kind, logic [15:0] value,
                                           logic [15:0] estart, logic [15:0] ecount);
        t_res r;
        r = '0;
        r.kind = kind;
        r.value_out = value;
        r.echo_start = estart;
        r.echo_count = ecount;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic logic [15:0] pick_span();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(1, BANK_DEPTH));
        end
        return 16'($urandom_range(1, 4));
    endfunction

    function automatic logic [15:0] pick_index();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return 16'(BANK_DEPTH + 1);
            end
            2: begin
                return 16'($urandom);
            end
            default: begin
                return 16'($urandom_range(1, BANK_DEPTH));
            end
        endcase
    endfunction

    // append one expected result to the scoreboard
    task automatic book_reply(input t_res r);
        replies_due.insert(replies_due.size(), r);
    endtask

    // bank behaviour: updates the copy of the bank and queues the replies of one request
    task automatic bank_response(input t_req r);
        logic [16:0] reach;
        bit          fits;
        int          last_change;
        t_res        x;
        reach = {1'b0, r.start} + {1'b0, r.count};
        fits = (r.count != 0) && (reach <= 17'(BANK_DEPTH));
        case (r.op)
            OP_READ: begin
                if (!fits) begin
                    book_reply(closing_reply(K_ERROR, '0, '0, '0));
                end else begin
                    x = '0;
                    x.kind = K_HEADER;
                    x.byte_count = 7'(r.count * 2);
                    book_reply(x);
                    for (int i = 0; i < int'(r.count); i++) begin
                        x = '0;
                        x.kind = K_DATA;
                        x.value_out = bank_regs[int'(r.start) + i];
                        x.last_result = (i == int'(r.count) - 1);
                        book_reply(x);
                    end
                end
            end
            OP_WRITE: begin
                if (fits && run_taken < r.count) begin
                    bank_regs[int'(r.start) + int'(run_taken)] = r.data;
                    run_taken = run_taken + 16'd1;
                end
                if (r.last) begin
                    run_taken = '0;
                    if (fits) begin
                        book_reply(closing_reply(K_ECHO, '0, r.start, r.count));
                    end else begin
                        book_reply(closing_reply(K_ERROR, '0, '0, '0));
                    end
                end
            end
            OP_SCAN: begin
                last_change = -1;
                for (int i = 0; i < BANK_DEPTH; i++) begin
                    if (shadow_regs[i] != bank_regs[i]) begin
                        last_change = i;
                    end
                end
                for (int i = 0; i < BANK_DEPTH; i++) begin
                    if (shadow_regs[i] != bank_regs[i]) begin
                        x = '0;
                        x.kind = K_CHANGE;
                        x.register_number = 6'(i + 1);
                        x.value_out = bank_regs[i];
                        x.last_result = (i == last_change);
                        book_reply(x);
                    end
                    shadow_regs[i] = bank_regs[i];
                end
            end
            OP_LWRITE: begin
                if (r.lidx >= 16'd1 && r.lidx <= 16'(BANK_DEPTH)) begin
                    bank_regs[int'(r.lidx) - 1] = r.data;
                end
            end
            OP_LREAD: begin
                if (r.lidx >= 16'd1 && r.lidx <= 16'(BANK_DEPTH)) begin
                    book_reply(closing_reply(K_LOCAL, bank_regs[int'(r.lidx) - 1],
                                             '0, '0));
                end else begin
                    book_reply(closing_reply(K_LOCAL, '0, '0, '0));
                end
            end
            default: begin
            end
        endcase
    endtask

    // offer one request, wait for it to be taken, then book its replies
    task automatic send_req(input t_req r, input bit typed, input t_res rep);
        int n0;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
        end
        push <= 1'b1;
        i_operation <= r.op;
        i_start_address <= r.start;
        i_word_count <= r.count;
        i_data_word <= r.data;
        i_local_index <= r.lidx;
        i_last_word <= r.last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left = burst_left - 1;
        random_sent = random_sent + 1;
        n0 = replies_due.size();
        bank_response(r);
        if (typed) begin
            while (replies_due.size() > n0) void'(replies_due.pop_back());
            book_reply(rep);
        end
    endtask

    task automatic add_row(logic [2:0] op, logic [15:0] start, logic [15:0] count,
                           logic [15:0] data, logic [15:0] lidx, logic last,
                           bit typed, t_res rep);
        t_script_row row;
        row.req = {op, start, count, data, lidx, last};
        row.has_reply = typed;
        row.reply = rep;
        script.insert(script.size(), row);
    endtask

    task automatic random_traffic();
        t_req r;
        int   pick;
        int   words;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            r.op = OP_SCAN;
            r.start = 16'($urandom);
            r.count = 16'($urandom);
            r.data = 16'($urandom);
            r.lidx = 16'($urandom);
            r.last = 1'($urandom_range(0, 1));
            if (pick < 25) begin
                r.op = OP_READ;
                r.count = pick_span();
                r.start = 16'($urandom_range(0, BANK_DEPTH - int'(r.count)));
                send_req(r, 1'b0, '0);
            end else if (pick < 50) begin
                r.op = OP_WRITE;
                r.count = pick_span();
                r.start = 16'($urandom_range(0, BANK_DEPTH - int'(r.count)));
                words = int'(r.count);
                case ($urandom_range(0, 7))
                    0: begin
                        words = words + $urandom_range(1, 2);
                    end
                    1: begin
                        words = $urandom_range(1, words);
                    end
                    default: begin
                    end
                endcase
                for (int w = 1; w <= words; w++) begin
                    r.data = 16'($urandom);
                    r.last = (w == words);
                    send_req(r, 1'b0, '0);
                end
            end else if (pick < 60) begin
                send_req(r, 1'b0, '0);
            end else if (pick < 75) begin
                r.op = OP_LWRITE;
                r.lidx = pick_index();
                send_req(r, 1'b0, '0);
            end else if (pick < 85) begin
                r.op = OP_LREAD;
                r.lidx = pick_index();
                send_req(r, 1'b0, '0);
            end else begin
                // noise, including broken ranges and stray write words
                r.op = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 1) == 1) begin
                    r.start = 16'($urandom_range(0, BANK_DEPTH + 1));
                    r.count = 16'($urandom_range(0, BANK_DEPTH + 1));
                end
                send_req(r, 1'b0, '0);
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0: begin
                pop <= 1'b1;
            end
            2'd1: begin
                pop <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                pop <= (stall_phase[2:0] != 3'd5);
            end
            default: begin
                pop <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && pop && !empty) begin
            got.kind = t_kind'(o_result_kind);
            got.byte_count = o_byte_count;
            got.register_number = o_register_number;
            got.value_out = o_value_out;
            got.echo_start = o_echo_start;
            got.echo_count = o_echo_count;
            got.last_result = o_last_result;
            if (replies_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: kind %0d value %h last %b",
                             o_result_kind, o_value_out, o_last_result);
                end
            end else begin
                want = replies_due.pop_front();
                if (got.kind !== want.kind || got.byte_count !== want.byte_count ||
                    got.register_number !== want.register_number ||
                    got.value_out !== want.value_out || got.echo_start !== want.echo_start ||
                    got.echo_count !== want.echo_count ||
                    got.last_result !== want.last_result) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("want kind %0d bytes %0d reg %0d value %h echo %h/%h last %b",
                                 want.kind, want.byte_count, want.register_number,
                                 want.value_out, want.echo_start, want.echo_count,
                                 want.last_result);
                        $display("got  kind %0d bytes %0d reg %0d value %h echo %h/%h last %b",
                                 o_result_kind, o_byte_count, o_register_number,
                                 o_value_out, o_echo_start, o_echo_count, o_last_result);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[modbus_holding_register_bank] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < BANK_DEPTH; i++) begin
            bank_regs[i] = '0;
            shadow_regs[i] = '0;
        end
        run_taken = '0;

        // after reset, range errors and local index extremes
        add_row(OP_LREAD, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0, 1'b1,
                closing_reply(K_LOCAL, 16'h0000, '0, '0));
        add_row(OP_READ, 16'd0, 16'd32, 16'd0, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_READ, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1,
                closing_reply(K_ERROR, '0, '0, '0));
        add_row(OP_READ, 16'd31, 16'd2, 16'd0, 16'd0, 1'b0, 1'b1,
                closing_reply(K_ERROR, '0, '0, '0));
        add_row(OP_READ, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1,
                closing_reply(K_ERROR, '0, '0, '0));
        add_row(OP_LWRITE, 16'd0, 16'd0, 16'hffff, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_LWRITE, 16'd0, 16'd0, 16'hffff, 16'd33, 1'b0, 1'b0, '0);
        add_row(OP_LWRITE, 16'd0, 16'd0, 16'hffff, 16'd1, 1'b0, 1'b0, '0);
        add_row(OP_LWRITE, 16'd0, 16'd0, 16'h8001, 16'd32, 1'b0, 1'b0, '0);
        add_row(OP_LREAD, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1,
                closing_reply(K_LOCAL, 16'h0000, '0, '0));
        add_row(OP_LREAD, 16'd0, 16'd0, 16'd0, 16'hffff, 1'b0, 1'b1,
                closing_reply(K_LOCAL, 16'h0000, '0, '0));
        add_row(OP_LREAD, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0, 1'b1,
                closing_reply(K_LOCAL, 16'hffff, '0, '0));
        add_row(OP_LREAD, 16'd0, 16'd0, 16'd0, 16'd32, 1'b0, 1'b1,
                closing_reply(K_LOCAL, 16'h8001, '0, '0));
        // write request at the top of the bank, then one that fails the check
        add_row(OP_WRITE, 16'd30, 16'd2, 16'h1234, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_WRITE, 16'd30, 16'd2, 16'habcd, 16'd0, 1'b1, 1'b1,
                closing_reply(K_ECHO, '0, 16'd30, 16'd2));
        add_row(OP_WRITE, 16'd32, 16'd1, 16'h5555, 16'd0, 1'b1, 1'b1,
                closing_reply(K_ERROR, '0, '0, '0));
        // surplus words in a run are dropped
        add_row(OP_WRITE, 16'd5, 16'd1, 16'h1111, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_WRITE, 16'd5, 16'd1, 16'h2222, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_WRITE, 16'd5, 16'd1, 16'h3333, 16'd0, 1'b1, 1'b1,
                closing_reply(K_ECHO, '0, 16'd5, 16'd1));
        add_row(OP_SCAN, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_SCAN, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_SPARE_FIRST, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0, '0);
        add_row(OP_SPARE_LAST, 16'd1, 16'd1, 16'd0, 16'd1, 1'b0, 1'b0, '0);
        add_row(OP_READ, 16'd30, 16'd2, 16'd0, 16'd0, 1'b0, 1'b0, '0);
        add_row(OP_LWRITE, 16'd0, 16'd0, 16'h0000, 16'd1, 1'b0, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            send_req(script[i].req, script[i].has_reply, script[i].reply);
        end
        random_traffic();
        push <= 1'b0;

        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[modbus_holding_register_bank] OK");
        end else begin
            $display("[modbus_holding_register_bank] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hrb_pkg.sv
rtl/core/hrb_front.sv
rtl/core/hrb_queue.sv
rtl/core/hrb_back.sv
rtl/core/modbus_holding_register_bank.sv
verif/tb_modbus_holding_register_bank.sv
